/* design/byte_register_machine_execute_macros.svh */
// Assertion macros shared by the execute unit's modules.
`ifndef BYTE_REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define BYTE_REGISTER_MACHINE_EXECUTE_MACROS_SVH
`ifndef ASSERT_OFF
`define BRM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BRM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BRM_ASSERT(label, clk, rst_n, prop, msg)
`define BRM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* design/brm_pkg.sv */
// Shared types, command codes and parameter defaults of the byte register machine.
package brm_pkg;
  localparam int RegCountDef     = 8;
  localparam int RamDepthDef     = 256;
  localparam int ProgramDepthDef = 256;
  localparam int QueueDepth      = 2;

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_AND    = 4'd2;
  localparam logic [3:0] CMD_OR     = 4'd3;
  localparam logic [3:0] CMD_INV    = 4'd4;
  localparam logic [3:0] CMD_SHL    = 4'd5;
  localparam logic [3:0] CMD_SHR    = 4'd6;
  localparam logic [3:0] CMD_STORE  = 4'd7;
  localparam logic [3:0] CMD_LOAD   = 4'd8;
  localparam logic [3:0] CMD_JUMP   = 4'd9;
  localparam logic [3:0] CMD_SKPCLR = 4'd10;
  localparam logic [3:0] CMD_SKPSET = 4'd11;
  localparam logic [3:0] CMD_SKPEQ  = 4'd12;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_IMM = 2'd1;

  // One classified instruction as it travels through the queue.
  typedef struct packed {
    logic [3:0] command;
    logic [3:0] dest_reg;
    logic [3:0] source_reg;
    logic [1:0] source_kind;
    logic [7:0] immediate;
    logic [7:0] mem_address;
    logic [7:0] jump_target;
    logic       label_found;
    logic       writes_reg;
    logic       is_store;
    logic       is_mem_load;
  } brm_op_t;

  typedef struct packed {
    logic [8:0]       next_index;
    logic signed [7:0] dest_value;
    logic             skipped;
    logic             done_res;
    logic             error_code;
  } brm_res_t;
endpackage

/* design/brm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module brm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

/* design/brm_front.sv */
// Front end: accepts instructions, classifies them and queues them for the back end.
module brm_front #(
  parameter int RegCount = brm_pkg::RegCountDef,
  parameter int RamDepth = brm_pkg::RamDepthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_command,
  input  logic [2:0]       in_dest_reg,
  input  logic [2:0]       in_source_reg,
  input  logic [1:0]       in_source_kind,
  input  logic [7:0]       in_immediate,
  input  logic [7:0]       in_mem_address,
  input  logic [7:0]       in_jump_target,
  input  logic             in_label_found,
  output logic             q_valid,
  output brm_pkg::brm_op_t q_op,
  input  logic             q_pop
);
  import brm_pkg::*;
  `include "byte_register_machine_execute_macros.svh"

  localparam int AddrW = $clog2(RamDepth);
  localparam int PtrW = $clog2(QueueDepth);

  brm_op_t            slot_r [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]      count_r, count_nxt;
  brm_op_t            op_new;
  logic               push;

  // Four subtractions wrap any register number below eight when RegCount >= 2.
  function automatic logic [3:0] wrap_reg(input logic [2:0] r);
    logic [4:0] w;
    w = {2'b00, r};
    for (int i = 0; i < 4; i++) begin
      if (w >= 5'(RegCount)) w = w - 5'(RegCount);
    end
    return w[3:0];
  endfunction

  always_comb begin
    op_new             = '0;
    op_new.command     = in_command;
    op_new.dest_reg    = wrap_reg(in_dest_reg);
    op_new.source_reg  = wrap_reg(in_source_reg);
    op_new.source_kind = in_source_kind;
    op_new.immediate   = in_immediate;
    op_new.mem_address = 8'(in_mem_address[AddrW-1:0]);
    op_new.jump_target = in_jump_target;
    op_new.label_found = in_label_found;
    op_new.writes_reg  = (in_command <= CMD_SHR) || (in_command == CMD_LOAD);
    op_new.is_store    = (in_command == CMD_STORE);
    op_new.is_mem_load = (in_command == CMD_LOAD) && in_source_kind[1];
  end

  assign in_stall = (count_r == (PtrW+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_op     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? PtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? PtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= op_new;
  end

  `BRM_ASSERT(a_no_pop_empty, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
  `BRM_ASSERT(a_count_bound, clk, rst_n, count_r <= (PtrW+1)'(QueueDepth), "queue overfull")
  `BRM_ASSERT(a_count_step, clk, rst_n,
    (push && !q_pop) |=> (count_r == $past(count_r) + 1'b1), "queue count slip")
endmodule

/* design/brm_back.sv */
// Back end: executes queued instructions against the register file and data memory.
module brm_back #(
  parameter int RegCount     = brm_pkg::RegCountDef,
  parameter int RamDepth     = brm_pkg::RamDepthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  brm_pkg::brm_op_t q_op,
  output logic             q_pop,
  input  logic [8:0]       program_length,
  output logic             out_valid,
  input  logic             out_stall,
  output brm_pkg::brm_res_t res
);
  import brm_pkg::*;
  `include "byte_register_machine_execute_macros.svh"

  localparam int RegW  = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int AddrW = $clog2(RamDepth);

  // Stage 1 holds the instruction while its memory byte is read; stage 2 is the
  // output register.
  logic              s1_valid_r;
  brm_op_t           s1_op_r;
  logic [7:0]        regs_r [RegCount];
  logic [RamDepth-1:0] mvalid_r;
  logic [8:0]        index_r, index_nxt;
  logic              halted_r, halted_nxt;
  logic              out_valid_r;
  brm_res_t          res_r, res_nxt;
  logic              s1_adv, out_free;
  logic [7:0]        ram_q, mem_byte, a, b, val, st_data;
  logic              reg_we, st_we, skip, err, done;
  logic [9:0]        next_w;
  logic [RegW-1:0]   d_i, s_i;
  logic [AddrW-1:0]  s1_addr, q_addr, rd_addr;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign q_pop     = q_valid && (!s1_valid_r || s1_adv);
  assign d_i       = s1_op_r.dest_reg[RegW-1:0];
  assign s_i       = s1_op_r.source_reg[RegW-1:0];
  assign s1_addr   = s1_op_r.mem_address[AddrW-1:0];
  assign q_addr    = q_op.mem_address[AddrW-1:0];
  // While stage 1 holds, keep reading its own byte so the read data stays valid.
  assign rd_addr   = q_pop ? q_addr : s1_addr;

  assign st_we   = s1_adv && !halted_r && s1_op_r.is_store && !s1_op_r.source_kind[1];
  assign st_data = (s1_op_r.source_kind == KIND_IMM) ? s1_op_r.immediate : b;

  brm_ram #(.Width(8), .Depth(RamDepth)) u_ram (
    .clk(clk), .wr_en(st_we), .wr_addr(s1_addr), .wr_data(st_data),
    .rd_addr(rd_addr), .rd_data(ram_q)
  );

  // Read data is forwarded when the preceding instruction stored to the same byte.
  always_comb begin
    if (fwd_hit_r) mem_byte = fwd_data_r;
    else if (!mvalid_r[s1_addr]) mem_byte = 8'd0;
    else mem_byte = ram_q;
  end

  always_comb begin
    a     = regs_r[d_i];
    b     = regs_r[s_i];
    val   = a;
    skip  = 1'b0;
    err   = 1'b0;
    reg_we = 1'b0;
    next_w = {1'b0, index_r} + 10'd1;
    case (s1_op_r.command)
      CMD_ADD: val = a + b;
      CMD_SUB: val = a - b;
      CMD_AND: val = a & b;
      CMD_OR:  val = a | b;
      CMD_INV: val = ~a;
      CMD_SHL: val = (b >= 8'd8) ? 8'd0 : 8'(a << b[2:0]);
      CMD_SHR: val = (b >= 8'd8) ? {8{a[7]}} : 8'($signed(a) >>> b[2:0]);
      CMD_STORE: val = (s1_op_r.source_kind[1]) ? mem_byte : st_data;
      CMD_LOAD: begin
        if (s1_op_r.source_kind == KIND_REG) val = b;
        else if (s1_op_r.source_kind == KIND_IMM) val = s1_op_r.immediate;
        else val = mem_byte;
      end
      CMD_JUMP: begin
        if (s1_op_r.label_found) next_w = {2'b00, s1_op_r.jump_target};
        else begin
          err    = 1'b1;
          next_w = {1'b0, index_r};
        end
      end
      CMD_SKPCLR: skip = !a[(b >= 8'd8) ? 3'd7 : b[2:0]];
      CMD_SKPSET: skip = a[(b >= 8'd8) ? 3'd7 : b[2:0]];
      CMD_SKPEQ:  skip = (a == b);
      default: ;
    endcase
    reg_we = s1_op_r.writes_reg;
    if (skip) next_w = {1'b0, index_r} + 10'd2;
    if (next_w > 10'd511) next_w = 10'd511;
    done = err || ({1'b0, next_w[8:0]} >= {1'b0, program_length});

    if (halted_r) begin
      res_nxt.next_index = index_r;
      res_nxt.dest_value = $signed(a);
      res_nxt.skipped    = 1'b0;
      res_nxt.done_res   = 1'b1;
      res_nxt.error_code = 1'b0;
      index_nxt          = index_r;
      halted_nxt         = 1'b1;
    end else begin
      res_nxt.next_index = next_w[8:0];
      res_nxt.dest_value = $signed(val);
      res_nxt.skipped    = skip;
      res_nxt.done_res   = done;
      res_nxt.error_code = err;
      index_nxt          = next_w[8:0];
      halted_nxt         = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      index_r     <= '0;
      halted_r    <= 1'b0;
      mvalid_r    <= '0;
      fwd_hit_r   <= 1'b0;
      for (int i = 0; i < RegCount; i++) regs_r[i] <= '0;
    end else begin
      if (q_pop) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (s1_adv) begin
        index_r  <= index_nxt;
        halted_r <= halted_nxt;
        if (!halted_r && reg_we) regs_r[d_i] <= val;
      end
      if (st_we) mvalid_r[s1_addr] <= 1'b1;
      if (q_pop) fwd_hit_r <= st_we && (s1_addr == q_addr);
    end
    if (q_pop) begin
      s1_op_r    <= q_op;
      fwd_data_r <= st_data;
    end
    if (s1_adv) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  `BRM_ASSERT(a_halt_sticky, clk, rst_n, halted_r |=> halted_r, "halt state left")
  `BRM_ASSERT(a_halt_done, clk, rst_n,
    (s1_adv && halted_r) |=> res_r.done_res, "halted result without done")
  `BRM_ASSERT(a_err_done, clk, rst_n,
    (out_valid_r && res_r.error_code) |-> res_r.done_res, "error without done")
endmodule

/* design/byte_register_machine_execute.sv */
// Top level of the byte register machine execute unit.
// The execute unit takes one decoded instruction per transaction and returns one
// result transaction per instruction: next index, value now in the destination
// (or the stored memory byte), skip flag, done flag and error code. A front end
// queues up to two instructions; the back end reads the data memory in stage 1
// and updates registers, memory and the index as the instruction moves to the
// output register, so while the result side does not stall, one instruction
// completes every clock. A store followed directly by a load from the same address
// is forwarded. The data memory reads as zero until written, tracked by one valid
// bit per byte, so no clearing pass runs after reset. Once done or in error, the
// unit stays halted until reset; program_length may be written only when idle.
module byte_register_machine_execute #(
  parameter int RegCount     = brm_pkg::RegCountDef,
  parameter int RamDepth     = brm_pkg::RamDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic [2:0]  in_dest_reg,
  input  logic [2:0]  in_source_reg,
  input  logic [1:0]  in_source_kind,
  input  logic [7:0]  in_immediate,
  input  logic [7:0]  in_mem_address,
  input  logic [7:0]  in_jump_target,
  input  logic        in_label_found,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_next_index,
  output logic signed [7:0] out_dest_value,
  output logic        out_skipped,
  output logic        out_done_res,
  output logic        out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_program_length
);
  import brm_pkg::*;

  logic       q_valid, q_pop;
  brm_op_t    q_op;
  brm_res_t   res;
  logic [8:0] program_length_r;

  // The length register is always ready to take a write.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) program_length_r <= 9'd256;
    else if (cfg_valid) program_length_r <= cfg_program_length;
  end

  brm_front #(.RegCount(RegCount), .RamDepth(RamDepth)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_dest_reg(in_dest_reg),
    .in_source_reg(in_source_reg), .in_source_kind(in_source_kind),
    .in_immediate(in_immediate), .in_mem_address(in_mem_address),
    .in_jump_target(in_jump_target), .in_label_found(in_label_found),
    .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop)
  );

  brm_back #(.RegCount(RegCount), .RamDepth(RamDepth)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop),
    .program_length(program_length_r), .out_valid(out_valid),
    .out_stall(out_stall), .res(res)
  );

  assign out_next_index = res.next_index;
  assign out_dest_value = res.dest_value;
  assign out_skipped    = res.skipped;
  assign out_done_res   = res.done_res;
  assign out_error_code = res.error_code;
endmodule

/* test/brm_execute_checker.sv */
// Checker for the byte register machine execute unit: predicts and compares every result.
`timescale 1ns / 1ps

module brm_execute_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [3:0]       in_command,
  input  logic [2:0]       in_dest_reg,
  input  logic [2:0]       in_source_reg,
  input  logic [1:0]       in_source_kind,
  input  logic [7:0]       in_immediate,
  input  logic [7:0]       in_mem_address,
  input  logic [7:0]       in_jump_target,
  input  logic             in_label_found,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [8:0]       out_next_index,
  input  logic signed [7:0] out_dest_value,
  input  logic             out_skipped,
  input  logic             out_done_res,
  input  logic             out_error_code,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [8:0]       cfg_program_length,
  output int               fail_count,
  output int               pending
);
  import brm_pkg::*;

  logic [7:0] regs [8];
  logic [7:0] mem [256];
  int unsigned pc;
  logic stopped;
  logic [8:0] prog_len;
  brm_res_t results_due [$];

  assign pending = results_due.size();

  function automatic logic bit_at(logic [7:0] v, logic [7:0] idx);
    return v[(idx >= 8) ? 3'd7 : idx[2:0]];
  endfunction

  // Executes one instruction on the shadow state and returns what the unit must report.
  function automatic brm_res_t execute_instr();
    brm_res_t r;
    logic [7:0] a, b, val;
    int unsigned nxt;
    logic skp, err;
    a = regs[in_dest_reg];
    b = regs[in_source_reg];
    val = a;
    skp = 0;
    err = 0;
    if (stopped) begin
      r.next_index = pc[8:0];
      r.dest_value = a;
      r.skipped = 0;
      r.done_res = 1;
      r.error_code = 0;
      return r;
    end
    nxt = pc + 1;
    case (in_command)
      CMD_ADD: val = a + b;
      CMD_SUB: val = a - b;
      CMD_AND: val = a & b;
      CMD_OR:  val = a | b;
      CMD_INV: val = ~a;
      CMD_SHL: val = (b >= 8) ? 8'h00 : (a << b);
      CMD_SHR: val = (b >= 8) ? {8{a[7]}} : 8'($signed(a) >>> b);
      CMD_STORE: begin
        if (in_source_kind == KIND_REG) mem[in_mem_address] = b;
        else if (in_source_kind == KIND_IMM) mem[in_mem_address] = in_immediate;
        val = mem[in_mem_address];
      end
      CMD_LOAD: begin
        if (in_source_kind == KIND_REG) val = b;
        else if (in_source_kind == KIND_IMM) val = in_immediate;
        else val = mem[in_mem_address];
      end
      CMD_JUMP: begin
        if (in_label_found) nxt = in_jump_target;
        else begin
          err = 1;
          nxt = pc;
        end
      end
      CMD_SKPCLR: skp = !bit_at(a, b);
      CMD_SKPSET: skp = bit_at(a, b);
      CMD_SKPEQ:  skp = (a == b);
      default: ;
    endcase
    if (in_command <= CMD_SHR || in_command == CMD_LOAD) regs[in_dest_reg] = val;
    if (skp) nxt = pc + 2;
    if (nxt > 511) nxt = 511;
    pc = nxt;
    stopped = err || (nxt >= prog_len);
    r.next_index = nxt[8:0];
    r.dest_value = val;
    r.skipped = skp;
    r.done_res = stopped;
    r.error_code = err;
    return r;
  endfunction

  always @(posedge clk) begin
    brm_res_t want;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = 0;
      stopped = 0;
      prog_len = 9'd256;
      results_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) prog_len = cfg_program_length;
      if (in_valid && !in_stall) results_due.push_back(execute_instr());
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected: next %0d value %0d", $time,
                   out_next_index, out_dest_value);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (want.next_index !== out_next_index || want.dest_value !== out_dest_value
              || want.skipped !== out_skipped || want.done_res !== out_done_res
              || want.error_code !== out_error_code) begin
            $display("%0t: mismatch expected next %0d val %0d skip %b done %b err %b",
                     $time, want.next_index, want.dest_value, want.skipped,
                     want.done_res, want.error_code);
            $display("%0t:          actual   next %0d val %0d skip %b done %b err %b",
                     $time, out_next_index, out_dest_value, out_skipped,
                     out_done_res, out_error_code);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

/* test/tb.sv */
// Testbench top for the byte register machine execute unit: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import brm_pkg::*;

  // Command codes the unit treats as no-ops, and the load/store kinds beyond
  // register and immediate.
  localparam logic [3:0] CMD_SPARE_LO = 4'd13;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;
  localparam logic [1:0] KIND_MEM = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [3:0] cmd;
    logic [2:0] rd;
    logic [2:0] rs;
    logic [1:0] kind;
    logic [7:0] imm;
    logic [7:0] addr;
    logic [7:0] tgt;
    logic found;
  } instr_t;

  logic clk = 0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [3:0] in_command;
  logic [2:0] in_dest_reg, in_source_reg;
  logic [1:0] in_source_kind;
  logic [7:0] in_immediate, in_mem_address, in_jump_target;
  logic in_label_found;
  logic out_valid, out_stall;
  logic [8:0] out_next_index;
  logic signed [7:0] out_dest_value;
  logic out_skipped, out_done_res, out_error_code;
  logic cfg_valid, cfg_ready;
  logic [8:0] cfg_program_length;
  int fail_count, pending;
  // While set, neither side inserts idle cycles.
  logic quiet = 0;

  always #10 clk = ~clk;

  byte_register_machine_execute dut (.*);

  brm_execute_checker checker_i (.*);

  // The result side stalls at random, with a one-in-five chance, unless quiet is set.
  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  // Places one instruction on the input channel and waits for its transaction.
  // Valid is only dropped for an idle gap, so back-to-back items never see a
  // low-then-high pair of assignments in the same time step.
  task automatic send(input instr_t t);
    in_valid <= 1'b1;
    in_command <= t.cmd;
    in_dest_reg <= t.rd;
    in_source_reg <= t.rs;
    in_source_kind <= t.kind;
    in_immediate <= t.imm;
    in_mem_address <= t.addr;
    in_jump_target <= t.tgt;
    in_label_found <= t.found;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic instr_t mk(input logic [3:0] c, input logic [2:0] rd, input logic [2:0] rs,
                                input logic [1:0] k, input logic [7:0] imm,
                                input logic [7:0] addr, input logic [7:0] tgt,
                                input logic f);
    instr_t t;
    t.cmd = c; t.rd = rd; t.rs = rs; t.kind = k;
    t.imm = imm; t.addr = addr; t.tgt = tgt; t.found = f;
    return t;
  endfunction

  // Random instruction. Jumps always find their label and land below tgt_max,
  // which keeps the index inside the program until the final phase.
  function automatic instr_t rand_instr(input int tgt_max, input bit force_jump);
    instr_t t;
    t.cmd = ($urandom_range(0, 99) < 4) ? 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))
                                        : 4'($urandom_range(0, CMD_SKPEQ));
    if (force_jump) t.cmd = CMD_JUMP;
    t.rd = 3'($urandom);
    t.rs = 3'($urandom);
    t.kind = 2'($urandom);
    t.imm = 8'($urandom);
    t.addr = 8'($urandom);
    t.found = 1'($urandom);
    t.tgt = 8'($urandom);
    if (t.cmd == CMD_JUMP) begin
      t.found = 1'b1;
      t.tgt = 8'($urandom_range(0, tgt_max - 1));
    end
    return t;
  endfunction

  // Stops the input, waits for the unit to drain, lets its pipeline settle, then
  // writes program_length.
  task automatic set_length(input logic [8:0] len);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (5) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_program_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One phase of random instructions. A jump is forced once len/4 - 1 items have
  // passed without one, and each item moves the index by at most two, so it stays
  // below len. The phase ends with a jump to index zero so the next program starts
  // inside its length.
  task automatic run_phase(input int len, input int count, input int quiet_lo,
                           input int quiet_hi);
    int since_jump;
    instr_t t;
    since_jump = 0;
    for (int i = 0; i < count; i++) begin
      quiet <= (i >= quiet_lo && i < quiet_hi);
      t = rand_instr(len / 4, since_jump >= len / 4 - 1);
      since_jump = (t.cmd == CMD_JUMP) ? 0 : since_jump + 1;
      send(t);
      // Hold off once in the middle until every result has come back.
      if (i == count / 2) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
    end
    send(mk(CMD_JUMP, 0, 0, KIND_REG, 0, 0, 8'd0, 1));
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= '0;
    in_dest_reg <= '0;
    in_source_reg <= '0;
    in_source_kind <= '0;
    in_immediate <= '0;
    in_mem_address <= '0;
    in_jump_target <= '0;
    in_label_found <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_program_length <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_length(9'd256);
    // Directed part: operand extremes, every operation and the corner cases.
    send(mk(CMD_LOAD, 0, 0, KIND_IMM, 8'h80, 0, 0, 0));
    send(mk(CMD_LOAD, 1, 0, KIND_IMM, 8'h7F, 0, 0, 0));
    send(mk(CMD_LOAD, 2, 0, KIND_IMM, 8'hFF, 0, 0, 0));
    send(mk(CMD_LOAD, 3, 0, KIND_IMM, 8'd8, 0, 0, 0));
    send(mk(CMD_ADD, 1, 2, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SUB, 0, 2, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_AND, 2, 0, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_OR, 4, 2, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_INV, 5, 0, KIND_REG, 0, 0, 0, 0));
    // Shift by eight and by a negative amount both saturate.
    send(mk(CMD_LOAD, 6, 0, KIND_IMM, 8'h81, 0, 0, 0));
    send(mk(CMD_SHR, 6, 3, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SHL, 1, 5, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SHR, 0, 7, KIND_REG, 0, 0, 0, 0));
    // Stores from register, immediate and the memory kind that writes nothing.
    send(mk(CMD_STORE, 0, 2, KIND_REG, 0, 8'hFF, 0, 0));
    send(mk(CMD_STORE, 0, 0, KIND_IMM, 8'h5A, 8'h00, 0, 0));
    send(mk(CMD_STORE, 0, 0, KIND_MEM, 8'h11, 8'h00, 0, 0));
    send(mk(CMD_LOAD, 7, 0, KIND_MEM, 0, 8'h00, 0, 0));
    send(mk(CMD_LOAD, 7, 0, KIND_SPARE, 0, 8'hFF, 0, 0));
    // Bit tests with an out-of-range index look at the sign bit.
    send(mk(CMD_SKPSET, 2, 3, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SKPCLR, 1, 2, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SKPEQ, 4, 4, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SPARE_LO, 0, 0, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_SPARE_HI, 0, 0, KIND_REG, 0, 0, 0, 0));
    send(mk(CMD_JUMP, 0, 0, KIND_REG, 0, 0, 8'd255, 1));
    send(mk(CMD_JUMP, 0, 0, KIND_REG, 0, 0, 8'd0, 1));

    run_phase(256, 230, 60, 150);
    set_length(9'd64);
    run_phase(64, 230, -1, -1);
    set_length(9'd160);
    run_phase(160, 230, -1, -1);

    // Final phase: the shortest program halts the unit, either by length or
    // by a jump to a missing label; the items after the halt see the halted state.
    quiet <= 1'b0;
    set_length(9'd1);
    if ($urandom_range(0, 1))
      send(mk(CMD_JUMP, 0, 0, KIND_REG, 0, 0, 8'd3, 0));
    else
      send(rand_instr(4, 0));
    for (int i = 0; i < 8; i++) send(rand_instr(4, 0));
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/brm_pkg.sv
design/brm_ram.sv
design/brm_front.sv
design/brm_back.sv
design/byte_register_machine_execute.sv
test/brm_execute_checker.sv
test/tb.sv
